/* sv/page_buffer_pool_manager_unit_assert.svh */
// Assertion macros for the page buffer pool manager RTL.
`ifndef PAGE_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH
`define PAGE_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/pbpm_pkg.sv */
package pbpm_pkg;

	localparam int FRAMES    = 16;
	localparam int FW        = $clog2(FRAMES);
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int PAGE_W    = 31;
	localparam int PIN_W     = 8;
	localparam int PIN_LIMIT = 255;

	// Configuration register indexes.
	localparam logic REG_INST_COUNT = 1'b0;
	localparam logic REG_INST_INDEX = 1'b1;

	// Request types.
	localparam logic [2:0] REQ_NEW       = 3'd0;
	localparam logic [2:0] REQ_FETCH     = 3'd1;
	localparam logic [2:0] REQ_UNPIN     = 3'd2;
	localparam logic [2:0] REQ_DELETE    = 3'd3;
	localparam logic [2:0] REQ_FLUSH     = 3'd4;
	localparam logic [2:0] REQ_FLUSH_ALL = 3'd5;

	// Disk command codes of a result beat.
	localparam logic [1:0] DISK_NONE  = 2'd0;
	localparam logic [1:0] DISK_WRITE = 2'd1;
	localparam logic [1:0] DISK_READ  = 2'd2;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [PAGE_W-1:0] page;
		logic              dirty;
		logic              known;
	} pbpm_req_t;

	typedef struct packed {
		logic [1:0]        disk_op;
		logic [PAGE_W-1:0] disk_page;
		logic              ok;
		logic [3:0]        frame_index;
		logic [PAGE_W-1:0] result_page;
		logic              clear_frame;
		logic              last;
	} pbpm_res_t;

endpackage

/* sv/pbpm_front.sv */
module pbpm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          req_type,
	input  logic [30:0]         req_page,
	input  logic                mark_dirty,
	output logic                q_valid,
	output pbpm_pkg::pbpm_req_t q_data,
	input  logic                q_pop
);
	import pbpm_pkg::*;

	pbpm_req_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       acc;
	pbpm_req_t  cls;

	assign full    = (cnt_q == 2'd2);
	assign acc     = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data  = ent_q[rd_q];

	// Classify the incoming beat: unknown request types are flagged here.
	always_comb begin
		cls.req_type = req_type;
		cls.page     = req_page;
		cls.dirty    = mark_dirty;
		cls.known    = (req_type <= REQ_FLUSH_ALL);
	end

	// Two-entry request queue toward the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wr_q <= !wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, q_pop && q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wr_q] <= cls;
		end
	end

endmodule

/* sv/pbpm_rq.sv */
module pbpm_rq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_push,
	input  pbpm_pkg::pbpm_res_t res_in,
	output logic                res_full,
	output logic                empty,
	input  logic                pop,
	output pbpm_pkg::pbpm_res_t res_out
);
	import pbpm_pkg::*;

	pbpm_res_t  ent_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (cnt_q == 3'd4);
	assign empty    = (cnt_q == 3'd0);
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;
	assign res_out  = ent_q[rd_q];

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, do_push} - {2'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= res_in;
		end
	end

endmodule

/* sv/pbpm_back.sv */
`include "page_buffer_pool_manager_unit_assert.svh"

module pbpm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  pbpm_pkg::pbpm_req_t req,
	output logic                req_pop,
	input  logic [4:0]          instance_count,
	input  logic [3:0]          inst_index,
	input  logic                rq_full,
	output logic                res_push,
	output pbpm_pkg::pbpm_res_t res
);
	import pbpm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_WB    = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_FLALL = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        st_q;
	pbpm_req_t         cur_q;

	// Frame directory.
	logic [PAGE_W-1:0] page_q  [FRAMES];
	logic [FRAMES-1:0] valid_q;
	logic [PIN_W-1:0]  pins_q  [FRAMES];
	logic [FRAMES-1:0] dirty_q;

	// Free frame ring and LRU list.
	logic [FW-1:0]     fifo_q  [FRAMES];
	logic [FW-1:0]     fhead_q;
	logic [CNT_W-1:0]  fcnt_q;
	logic [FW-1:0]     lru_q   [FRAMES];
	logic [CNT_W-1:0]  lcnt_q;

	logic [PAGE_W-1:0] ctr_q;
	logic [PAGE_W-1:0] prod_q;
	logic              hit_q;
	logic [FW-1:0]     hitf_q;

	// Emission plan prepared by the execute step.
	logic              wb_need_q;
	logic [PAGE_W-1:0] wb_page_q;
	logic              rd_need_q;
	logic              done_ok_q;
	logic [FW-1:0]     done_frame_q;
	logic [PAGE_W-1:0] done_rpage_q;
	logic              done_clr_q;
	logic [FW-1:0]     fa_idx_q;

	logic [FRAMES-1:0] match;
	logic              hit;
	logic [FW-1:0]     hitf;
	logic [35:0]       prod_full;
	logic [PAGE_W-1:0] pid;

	logic              take_free;
	logic              take_ok;
	logic [FW-1:0]     take_f;
	logic [FW:0]       tail_sum;
	logic [FW-1:0]     tail;

	logic              rm_en;
	logic [FW-1:0]     rm_f;
	logic [FRAMES-1:0] rm_m;
	logic              rm_go;
	logic [FW-1:0]     rm_pos;
	logic              add_en;
	logic [FRAMES-1:0] add_m;
	logic              add_go;

	logic              exec_take;
	logic              fetch_hit_ok;
	logic              unpin_ok;
	logic              del_ok;

	// Parallel page lookup, lowest matching frame wins.
	always_comb begin
		hit  = 1'b0;
		hitf = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (page_q[i] == cur_q.page);
			if (match[i]) begin
				hit  = 1'b1;
				hitf = FW'(i);
			end
		end
	end

	assign prod_full = {5'b0, ctr_q} * {31'b0, instance_count};
	assign pid       = prod_q + {{(PAGE_W-4){1'b0}}, inst_index};

	// Frame source: free ring first, otherwise the oldest LRU entry.
	assign take_free = (fcnt_q != '0);
	assign take_ok   = take_free || (lcnt_q != '0);
	assign take_f    = take_free ? fifo_q[fhead_q] : lru_q[0];
	assign tail_sum  = {1'b0, fhead_q} + fcnt_q[FW:0];
	assign tail      = (tail_sum >= (FW+1)'(FRAMES)) ? FW'(tail_sum - (FW+1)'(FRAMES))
		: tail_sum[FW-1:0];

	// Decisions of the execute step.
	assign exec_take    = (st_q == ST_EXEC) && cur_q.known &&
		((cur_q.req_type == REQ_NEW) || ((cur_q.req_type == REQ_FETCH) && !hit_q));
	assign fetch_hit_ok = hit_q && (pins_q[hitf_q] < PIN_W'(PIN_LIMIT));
	assign unpin_ok     = hit_q && (pins_q[hitf_q] != '0);
	assign del_ok       = hit_q && (pins_q[hitf_q] == '0);

	// One removal from the LRU list per execute step.
	always_comb begin
		rm_en = 1'b0;
		rm_f  = hitf_q;
		if (exec_take && !take_free && take_ok) begin
			rm_en = 1'b1;
			rm_f  = lru_q[0];
		end else if ((st_q == ST_EXEC) && cur_q.known) begin
			if ((cur_q.req_type == REQ_FETCH) && fetch_hit_ok) begin
				rm_en = 1'b1;
			end
			if ((cur_q.req_type == REQ_DELETE) && del_ok) begin
				rm_en = 1'b1;
			end
		end
		rm_go  = 1'b0;
		rm_pos = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			rm_m[i] = (lru_q[i] == rm_f) && (CNT_W'(i) < lcnt_q);
			if (rm_m[i]) begin
				rm_go  = rm_en;
				rm_pos = FW'(i);
			end
		end
	end

	// Append to the LRU list when an unpin drops the last pin.
	always_comb begin
		add_en = (st_q == ST_EXEC) && cur_q.known && (cur_q.req_type == REQ_UNPIN) &&
			unpin_ok && (pins_q[hitf_q] == PIN_W'(1));
		for (int i = 0; i < FRAMES; i++) begin
			add_m[i] = (lru_q[i] == hitf_q) && (CNT_W'(i) < lcnt_q);
		end
		add_go = add_en && !(|add_m) && (lcnt_q < CNT_W'(FRAMES));
	end

	// Result beat presented to the queue.
	always_comb begin
		res_push = 1'b0;
		res      = '0;
		case (st_q)
			ST_WB: begin
				res_push      = wb_need_q && !rq_full;
				res.disk_op   = DISK_WRITE;
				res.disk_page = wb_page_q;
			end
			ST_RD: begin
				res_push      = rd_need_q && !rq_full;
				res.disk_op   = DISK_READ;
				res.disk_page = cur_q.page;
			end
			ST_FLALL: begin
				res_push      = valid_q[fa_idx_q] && !rq_full;
				res.disk_op   = DISK_WRITE;
				res.disk_page = page_q[fa_idx_q];
			end
			ST_DONE: begin
				res_push        = !rq_full;
				res.disk_op     = DISK_NONE;
				res.ok          = done_ok_q;
				res.frame_index = 4'(done_frame_q);
				res.result_page = done_rpage_q;
				res.clear_frame = done_clr_q;
				res.last        = 1'b1;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	assign req_pop = (st_q == ST_IDLE) && req_valid;

	// Sequencer and directory state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			valid_q   <= '0;
			dirty_q   <= '0;
			fhead_q   <= '0;
			fcnt_q    <= CNT_W'(FRAMES);
			lcnt_q    <= '0;
			ctr_q     <= '0;
			wb_need_q <= 1'b0;
			rd_need_q <= 1'b0;
			fa_idx_q  <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				pins_q[i] <= '0;
				fifo_q[i] <= FW'(i);
			end
		end else begin
			if (rm_go) begin
				lcnt_q <= lcnt_q - CNT_W'(1);
			end else if (add_go) begin
				lcnt_q <= lcnt_q + CNT_W'(1);
			end
			case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						st_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					st_q <= ST_EXEC;
				end
				ST_EXEC: begin
					wb_need_q    <= 1'b0;
					rd_need_q    <= 1'b0;
					done_ok_q    <= 1'b0;
					done_frame_q <= '0;
					done_rpage_q <= '0;
					done_clr_q   <= 1'b0;
					st_q         <= ST_WB;
					if (!cur_q.known) begin
						st_q <= ST_DONE;
					end else begin
						case (cur_q.req_type)
							REQ_NEW, REQ_FETCH: begin
								if ((cur_q.req_type == REQ_FETCH) && hit_q) begin
									if (fetch_hit_ok) begin
										pins_q[hitf_q] <= pins_q[hitf_q] + PIN_W'(1);
										done_ok_q      <= 1'b1;
										done_frame_q   <= hitf_q;
										done_rpage_q   <= cur_q.page;
									end
								end else if (take_ok) begin
									if (take_free) begin
										fhead_q <= (fhead_q == FW'(FRAMES - 1)) ? '0
											: fhead_q + FW'(1);
										fcnt_q  <= fcnt_q - CNT_W'(1);
									end else begin
										wb_need_q <= valid_q[take_f] && dirty_q[take_f];
										wb_page_q <= page_q[take_f];
									end
									valid_q[take_f] <= 1'b1;
									dirty_q[take_f] <= 1'b0;
									pins_q[take_f]  <= PIN_W'(1);
									done_ok_q       <= 1'b1;
									done_frame_q    <= take_f;
									if (cur_q.req_type == REQ_NEW) begin
										ctr_q        <= ctr_q + PAGE_W'(1);
										done_rpage_q <= pid;
										done_clr_q   <= 1'b1;
									end else begin
										rd_need_q    <= 1'b1;
										done_rpage_q <= cur_q.page;
									end
								end
							end
							REQ_UNPIN: begin
								if (unpin_ok) begin
									if (cur_q.dirty) begin
										dirty_q[hitf_q] <= 1'b1;
									end
									pins_q[hitf_q] <= pins_q[hitf_q] - PIN_W'(1);
									done_ok_q      <= 1'b1;
								end
							end
							REQ_DELETE: begin
								if (!hit_q) begin
									done_ok_q <= 1'b1;
								end else if (del_ok) begin
									wb_need_q       <= dirty_q[hitf_q];
									wb_page_q       <= cur_q.page;
									valid_q[hitf_q] <= 1'b0;
									dirty_q[hitf_q] <= 1'b0;
									pins_q[hitf_q]  <= '0;
									if (fcnt_q < CNT_W'(FRAMES)) begin
										fifo_q[tail] <= hitf_q;
										fcnt_q       <= fcnt_q + CNT_W'(1);
									end
									done_ok_q    <= 1'b1;
									done_frame_q <= hitf_q;
									done_clr_q   <= 1'b1;
								end
							end
							REQ_FLUSH: begin
								if (hit_q) begin
									dirty_q[hitf_q] <= 1'b0;
									wb_need_q       <= 1'b1;
									wb_page_q       <= cur_q.page;
									done_ok_q       <= 1'b1;
								end
							end
							REQ_FLUSH_ALL: begin
								fa_idx_q  <= '0;
								done_ok_q <= 1'b1;
								st_q      <= ST_FLALL;
							end
							default: begin
								st_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WB: begin
					if (!wb_need_q || !rq_full) begin
						st_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (!rd_need_q || !rq_full) begin
						st_q <= ST_DONE;
					end
				end
				ST_FLALL: begin
					if (!valid_q[fa_idx_q] || !rq_full) begin
						dirty_q[fa_idx_q] <= 1'b0;
						if (fa_idx_q == FW'(FRAMES - 1)) begin
							st_q <= ST_DONE;
						end else begin
							fa_idx_q <= fa_idx_q + FW'(1);
						end
					end
				end
				ST_DONE: begin
					if (!rq_full) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture, lookup and product registers, page ids and LRU entries.
	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q <= req;
		end
		if (st_q == ST_LOOK) begin
			hit_q  <= hit;
			hitf_q <= hitf;
			prod_q <= prod_full[PAGE_W-1:0];
		end
		if (exec_take && take_ok) begin
			page_q[take_f] <= (cur_q.req_type == REQ_NEW) ? pid : cur_q.page;
		end
		if (rm_go) begin
			for (int j = 0; j < FRAMES - 1; j++) begin
				if (FW'(j) >= rm_pos) begin
					lru_q[j] <= lru_q[j+1];
				end
			end
		end else if (add_go) begin
			lru_q[lcnt_q[FW-1:0]] <= hitf_q;
		end
	end

	`PBPM_ASSERT_IMP(a_frames_bounded, 1'b1,
		({1'b0, fcnt_q} + {1'b0, lcnt_q}) <= (CNT_W+1)'(FRAMES),
		"free and LRU frames exceed the pool")
	`PBPM_ASSERT_IMP(a_push_room, res_push, !rq_full,
		"result pushed into a full queue")
	`PBPM_ASSERT_NXT(a_done_idle, (st_q == ST_DONE) && !rq_full, st_q == ST_IDLE,
		"completion beat did not end the request")
	`PBPM_ASSERT_IMP(a_lru_single, rm_go, !add_go,
		"LRU list removal and append in one cycle")

endmodule

/* sv/page_buffer_pool_manager_unit.sv */
// Channel   | Handshake                    | Payload
// request   | push / full                  | req_type, req_page, mark_dirty
// result    | pop / empty                  | disk_op, disk_page, ok, frame_index,
//           |                              | result_page, clear_frame, last
// config    | wr_en (no wait)              | wr_index, wr_data
// An accepted beat is registered in the request queue first; the back end then takes
// a known request through accept, lookup, execute, write-back slot, read slot and
// completion whatever beats it yields; an unknown type skips both slots. Flush all
// walks the sixteen frames one per cycle unless stalled, in place of both disk slots.
// The back-end sequencer handles one request at a time; a two-entry request queue
// and a four-entry result queue decouple it from both sides.
// Reset empties both queues, invalidates every frame and refills the free ring in order.
// A full result queue stalls the sequencer in place without losing beats.
module page_buffer_pool_manager_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  logic [30:0] req_page,
	input  logic        mark_dirty,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  disk_op,
	output logic [30:0] disk_page,
	output logic        ok,
	output logic [3:0]  frame_index,
	output logic [30:0] result_page,
	output logic        clear_frame,
	output logic        last,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [4:0]  wr_data
);
	import pbpm_pkg::*;

	logic [4:0] inst_count_q;
	logic [3:0] inst_index_q;
	logic       q_valid;
	pbpm_req_t  q_data;
	logic       q_pop;
	logic       rq_full;
	logic       res_push;
	pbpm_res_t  res_in;
	pbpm_res_t  res_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_count_q <= 5'd1;
			inst_index_q <= 4'd0;
		end else if (wr_en) begin
			case (wr_index)
				REG_INST_COUNT: inst_count_q <= wr_data;
				REG_INST_INDEX: inst_index_q <= wr_data[3:0];
				default: inst_count_q <= inst_count_q;
			endcase
		end
	end

	pbpm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.req_page   (req_page),
		.mark_dirty (mark_dirty),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop)
	);

	pbpm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (q_valid),
		.req            (q_data),
		.req_pop        (q_pop),
		.instance_count (inst_count_q),
		.inst_index     (inst_index_q),
		.rq_full        (rq_full),
		.res_push       (res_push),
		.res            (res_in)
	);

	pbpm_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (rq_full),
		.empty    (empty),
		.pop      (pop),
		.res_out  (res_out)
	);

	assign disk_op     = res_out.disk_op;
	assign disk_page   = res_out.disk_page;
	assign ok          = res_out.ok;
	assign frame_index = res_out.frame_index;
	assign result_page = res_out.result_page;
	assign clear_frame = res_out.clear_frame;
	assign last        = res_out.last;

endmodule
